>>> src/mpq_pkg.sv
// Shared definitions for the minimum priority queue: sizes, codes and payload types.
// Used by mpq_min_unit and min_priority_queue_core; depends on nothing else.
package mpq_pkg;

  // Capacity of the entry store and the widths that follow from it.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the transaction payloads.
  localparam int TAG_W    = 8;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // Operation codes.
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // One command transaction.
  typedef struct packed {
    logic                    kind;
    logic [TAG_W-1:0]        tag_in;
    logic signed [KEY_W-1:0] key_in;
  } cmd_t;

  // One response transaction.
  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [TAG_W-1:0]        tag_out;
    logic signed [KEY_W-1:0] key_out;
    logic [OCC_W-1:0]        occupancy;
  } rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [TAG_W-1:0]        tag;
    logic signed [KEY_W-1:0] key;
  } entry_t;

  // Running minimum reported by the compare unit.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    entry_t           entry;
  } best_t;

endpackage

>>> src/mpq_min_unit.sv
// Shared running-minimum unit: one signed key comparator and the best-so-far register.
// Depends on mpq_pkg for the entry and result types.
module mpq_min_unit (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       first,
  input  logic [mpq_pkg::IDX_W-1:0]  idx,
  input  mpq_pkg::entry_t            entry,
  output mpq_pkg::best_t             best
);

  logic take;

  // Strictly smaller replaces the held entry, so the earliest wins on equal keys.
  assign take = first || (entry.key < best.entry.key);

  // Best-so-far register, loaded by the first entry of a scan and by any strictly smaller key.
  always_ff @(posedge clk) begin
    if (en && take) begin
      best.idx   <= idx;
      best.entry <= entry;
    end
  end

endmodule

>>> src/min_priority_queue_core.sv
// Top level of the bounded minimum priority queue with linear-scan removal.
// Depends on mpq_pkg and instantiates mpq_min_unit.
//
//   Channel | Signals                     | Transaction
//   --------+-----------------------------+-------------------------------------
//   command | cmd_valid, cmd_stall, cmd   | insert (tag, key) or remove smallest
//   result  | rsp_valid, rsp_stall, rsp   | status, removed tag/key, occupancy
//
// Inserts, full or not, and a remove on an empty queue go straight to the finish step.
// A remove scans the held entries, one scan read a cycle through the single store
// read port, then moves every entry behind the removed one down by one place, one
// shift a cycle to close the gap.
// Reset is synchronous and empties the queue; the store itself is not cleared.
// cmd_stall is high while a transaction is in progress; a finished result waits in
// the output register while rsp_stall is high and the next command may still be taken.
module min_priority_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  mpq_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mpq_pkg::rsp_t rsp
);

  localparam int IDX_W = mpq_pkg::IDX_W;
  localparam int CNT_W = mpq_pkg::CNT_W;
  localparam int OCC_W = mpq_pkg::OCC_W;
  localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(mpq_pkg::DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CSTART,
    S_COMPACT,
    S_FINISH
  } state_t;

  state_t                         state;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;
  logic [CNT_W-1:0]               scan_idx;
  logic [IDX_W-1:0]               pend_idx;
  logic [IDX_W-1:0]               cidx;
  logic [CNT_W-1:0]               cidx_ahead;
  logic [CNT_W-1:0]               best_after;
  logic                           is_remove;
  logic [mpq_pkg::STATUS_W-1:0]   res_status;

  // Entry store: one write and one registered read a cycle.
  mpq_pkg::entry_t                store [mpq_pkg::DEPTH];
  mpq_pkg::entry_t                rd_data;
  logic [IDX_W-1:0]               rd_addr;
  logic                           wr_en;
  logic [IDX_W-1:0]               wr_addr;
  mpq_pkg::entry_t                wr_data;

  mpq_pkg::best_t                 best;
  logic                           min_en;
  logic                           room;

  assign cmd_stall  = (state != S_IDLE);
  assign room       = (count < CAPACITY);
  assign cidx_ahead = CNT_W'(cidx) + CNT_W'(2);
  assign best_after = CNT_W'(best.idx) + CNT_W'(1);
  assign min_en     = (state == S_SCAN);

  // Occupancy after the transaction in progress.
  always_comb begin
    if (res_status != mpq_pkg::ST_DONE) begin
      count_next = count;
    end else if (is_remove) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count + CNT_W'(1);
    end
  end

  // Store address and write selection for each step of the sequencer.
  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cidx;
    wr_data = rd_data;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid && (cmd.kind == mpq_pkg::KIND_INSERT) && room) begin
          wr_en   = 1'b1;
          wr_addr = count[IDX_W-1:0];
          wr_data = '{tag: cmd.tag_in, key: cmd.key_in};
        end
      end
      S_SCAN: begin
        rd_addr = scan_idx[IDX_W-1:0];
      end
      S_CSTART: begin
        rd_addr = best_after[IDX_W-1:0];
      end
      S_COMPACT: begin
        wr_en   = 1'b1;
        rd_addr = cidx_ahead[IDX_W-1:0];
      end
      S_FINISH: begin
        rd_addr = '0;
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Store write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data <= store[rd_addr];
  end

  // Shared comparator, fed one stored entry a cycle during the scan.
  mpq_min_unit u_min (
    .clk   (clk),
    .en    (min_en),
    .first (pend_idx == '0),
    .idx   (pend_idx),
    .entry (rd_data),
    .best  (best)
  );

  // Sequencer, fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A finishing transaction refills the result register itself.
      if (rsp_valid && !rsp_stall && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            is_remove <= (cmd.kind == mpq_pkg::KIND_REMOVE);
            if (cmd.kind == mpq_pkg::KIND_INSERT) begin
              res_status <= room ? mpq_pkg::ST_DONE : mpq_pkg::ST_FULL;
              state      <= S_FINISH;
            end else if (count == '0) begin
              res_status <= mpq_pkg::ST_EMPTY;
              state      <= S_FINISH;
            end else begin
              res_status <= mpq_pkg::ST_DONE;
              scan_idx   <= CNT_W'(1);
              pend_idx   <= '0;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx < count) begin
            pend_idx <= scan_idx[IDX_W-1:0];
            scan_idx <= scan_idx + CNT_W'(1);
          end else begin
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          cidx <= best.idx;
          if (best_after < count) begin
            state <= S_COMPACT;
          end else begin
            state <= S_FINISH;
          end
        end
        S_COMPACT: begin
          cidx <= cidx + IDX_W'(1);
          if (!(cidx_ahead < count)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.occupancy <= OCC_W'(count_next);
            if (is_remove && (res_status == mpq_pkg::ST_DONE)) begin
              rsp.tag_out <= best.entry.tag;
              rsp.key_out <= best.entry.key;
            end else begin
              rsp.tag_out <= '0;
              rsp.key_out <= '0;
            end
            count <= count_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CAPACITY)
    else $error("fill count above capacity");

  // The entry chosen by the scan lies within the held entries.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_CSTART) |-> (CNT_W'(best.idx) < count))
    else $error("scan chose an entry outside the queue");

  // Every shift writes a slot that is followed by a held entry.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT) |-> ((CNT_W'(cidx) + CNT_W'(1)) < count))
    else $error("compaction ran past the last entry");

  // A finishing transaction with a free result register presents its result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && (!rsp_valid || !rsp_stall)) |=> (rsp_valid && (state == S_IDLE)))
    else $error("result not presented on completion");

  // A remove on an empty queue is only reported when the queue is empty.
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_FINISH) && (res_status == mpq_pkg::ST_EMPTY)) |-> (count == '0))
    else $error("empty status with entries held");

endmodule

>>> tb/sv/min_priority_queue_core_tb.sv
// Self-checking testbench for min_priority_queue_core: a model of the queue predicts every result.
// Depends on mpq_pkg for the payload types, the capacity and the status and operation codes.
`timescale 1ns / 100ps

module min_priority_queue_core_tb;
  import mpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 50;
  localparam logic signed [KEY_W-1:0] KEY_LOWEST  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_HIGHEST = ~KEY_LOWEST;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Model of the entry store, in arrival order, and its fill level.
  entry_t model_entries [DEPTH];
  int     model_fill = 0;

  // Results predicted for accepted commands, oldest first.
  rsp_t due_results [$];
  rsp_t due_rsp;

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int rx_mode = 0;
  int rx_left = 0;

  min_priority_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Cycle counter with a hard stop should the queue hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Applies one command to the model and returns the result the queue should give.
  function automatic rsp_t predict_queue_result(cmd_t c);
    rsp_t r;
    int   best;
    r = '0;
    if (c.kind == KIND_INSERT) begin
      if (model_fill >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        model_entries[model_fill] = '{tag: c.tag_in, key: c.key_in};
        model_fill++;
      end
    end else if (model_fill == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Running minimum; a strict compare keeps the earliest of equal keys.
      best = 0;
      for (int i = 1; i < model_fill; i++) begin
        if (model_entries[i].key < model_entries[best].key) best = i;
      end
      r.tag_out = model_entries[best].tag;
      r.key_out = model_entries[best].key;
      for (int i = best; i + 1 < model_fill; i++) begin
        model_entries[i] = model_entries[i + 1];
      end
      model_fill--;
    end
    r.occupancy = OCC_W'(model_fill);
    return r;
  endfunction

  // Key source weighted towards the extremes and a narrow band that gives many ties.
  function automatic logic signed [KEY_W-1:0] random_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 5))
      0: k = KEY_LOWEST;
      1: k = KEY_HIGHEST;
      2: k = $signed(KEY_W'($urandom_range(0, 8))) - 4;
      default: k = $urandom;
    endcase
    return k;
  endfunction

  // Sends one command transaction in bursts with random gaps, then records its prediction.
  task automatic push_command(input logic kind, input logic [TAG_W-1:0] tag,
                              input logic signed [KEY_W-1:0] key);
    cmd_t item;
    int   gap;
    item.kind   = kind;
    item.tag_in = tag;
    item.key_in = key;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        cmd       <= cmd_t'({$urandom, $urandom});
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    cmd_valid <= 1'b1;
    cmd       <= item;
    do @(posedge clk); while (cmd_stall);
    due_results.push_back(predict_queue_result(item));
  endtask

  // Holds the sender back until every predicted result has been delivered.
  task automatic wait_for_drain();
    cmd_valid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (due_results.size() != 0);
  endtask

  // A remove on a queue that has never been filled; the ignored fields carry ones.
  task automatic test_remove_on_empty();
    push_command(KIND_REMOVE, 8'hFF, -1);
  endtask

  // The extreme keys come out in signed order, not in arrival order.
  task automatic test_key_extremes();
    push_command(KIND_INSERT, 8'hFF, KEY_HIGHEST);
    push_command(KIND_INSERT, 8'h00, KEY_LOWEST);
    push_command(KIND_INSERT, 8'hA5, 0);
    push_command(KIND_INSERT, 8'h5A, -1);
    repeat (4) push_command(KIND_REMOVE, 8'h00, 0);
  endtask

  // Equal smallest keys leave in the order they arrived.
  task automatic test_equal_keys();
    push_command(KIND_INSERT, 8'd4, 9);
    push_command(KIND_INSERT, 8'd1, 7);
    push_command(KIND_INSERT, 8'd2, 7);
    push_command(KIND_INSERT, 8'd3, 7);
    repeat (4) push_command(KIND_REMOVE, TAG_W'($urandom), $urandom);
  endtask

  // Fills the queue past capacity with random entries, then drains it past empty.
  task automatic test_fill_and_drain();
    while (model_fill < DEPTH) push_command(KIND_INSERT, TAG_W'($urandom), random_key());
    repeat ($urandom_range(1, 2)) push_command(KIND_INSERT, TAG_W'($urandom), random_key());
    while (model_fill > 0) push_command(KIND_REMOVE, TAG_W'($urandom), $urandom);
    push_command(KIND_REMOVE, TAG_W'($urandom), $urandom);
  endtask

  // Mixed traffic in segments that lean towards inserts, removes or neither.
  task automatic test_random_traffic(input int count);
    int sent;
    int seg_left;
    int insert_pct;
    sent     = 0;
    seg_left = 0;
    insert_pct = 50;
    while (sent < count) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 20;
          default: insert_pct = 55;
        endcase
      end
      seg_left--;
      if ($urandom_range(0, 99) < insert_pct) begin
        push_command(KIND_INSERT, TAG_W'($urandom), random_key());
      end else begin
        push_command(KIND_REMOVE, TAG_W'($urandom), $urandom);
      end
      sent++;
    end
  endtask

  // Receiver stall pattern: free flow, light, heavy and periodic phases.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(30, 200);
    end
    rx_left--;
    case (rx_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= ((cycle_count % 16) < 5);
    endcase
  end

  // Compares each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && !rsp_stall) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: status %0d, occupancy %0d", rsp.status, rsp.occupancy);
        errors++;
      end else begin
        due_rsp = due_results.pop_front();
        if (rsp.status !== due_rsp.status) begin
          $error("status: expected %0d, got %0d", due_rsp.status, rsp.status);
          errors++;
        end
        if (rsp.tag_out !== due_rsp.tag_out) begin
          $error("tag_out: expected %0d, got %0d", due_rsp.tag_out, rsp.tag_out);
          errors++;
        end
        if (rsp.key_out !== due_rsp.key_out) begin
          $error("key_out: expected %0d, got %0d", due_rsp.key_out, rsp.key_out);
          errors++;
        end
        if (rsp.occupancy !== due_rsp.occupancy) begin
          $error("occupancy: expected %0d, got %0d", due_rsp.occupancy, rsp.occupancy);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_remove_on_empty();
    test_key_extremes();
    test_equal_keys();
    wait_for_drain();

    test_fill_and_drain();
    test_random_traffic(200);
    wait_for_drain();
    test_fill_and_drain();
    test_random_traffic(250);

    // Let the last results arrive, then keep watching for strays before the verdict.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
